// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/ltf_pkg.sv =====
`default_nettype none

package ltf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QuoW     = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOffMs     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOnMs      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpreadMs  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRestartMs = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMinBright = 3'd5;

  // Request kinds
  localparam logic ReqUpdate  = 1'b0;
  localparam logic ReqRestart = 1'b1;

  // LED phases
  localparam logic [1:0] PhSteady = 2'd0;
  localparam logic [1:0] PhDim    = 2'd1;
  localparam logic [1:0] PhBright = 2'd2;

  localparam logic [7:0] FullBright = 8'd255;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  led_index;
    logic [31:0] now_ms;
    logic [15:0] rand_a;
    logic [15:0] rand_b;
    logic [7:0]  base_red;
    logic [7:0]  base_green;
    logic [7:0]  base_blue;
  } in_t;

  typedef struct packed {
    logic [5:0] out_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] brightness;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic fin;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_ok;
    logic restart;
    logic need_div;
    logic out_free;
  } sts_t;

  // Scale one channel: (ch * (1 + b)) >> 8
  function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [7:0] b);
    logic [16:0] prod;
    prod = {9'd0, ch} * ({9'd0, b} + 17'd1);
    return prod[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_twinkle_fader_top.sv =====
// LED twinkle fader.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat is an update or a
// restart for one LED. Restarts and beats with an LED index at or beyond NUM_LEDS
// are taken while the controller stays idle and give no result. An update gives
// one result beat on the output channel (out_valid_o / out_ready_i / out_data_o).
// After acceptance an update passes the read and evaluate states, then goes to
// the output state when the LED is steady, switches phase or has a zero-length
// ramp; on a ramp a multiply, an 8-step restoring divider (one quotient bit a
// cycle) and a finish state compute the brightness first. One update is in
// flight at a time: a new beat is taken only when the controller is idle again.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following update holds in its final step
// until the waiting beat is taken, and input ready stays low meanwhile.
// Per-LED state (phase, start time, length) lives in a memory of NUM_LEDS words,
// read on acceptance and written at most once per item; it is not cleared by
// reset and an LED must see a restart before its first update.
// Reset clears the configuration registers, the controller and the output valid.
// Configuration writes (cfg_we_i) take effect at once; issue them while idle.
`default_nettype none

module led_twinkle_fader_top #(
  parameter int unsigned NUM_LEDS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ltf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ltf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ltf_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ltf_pkg::out_t                      out_data_o
);
  import ltf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: read state, evaluate, optional divide, emit.
  ltf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold configuration, LED state memory, divider and output register.
  ltf_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ltf_ctrl.sv =====
`default_nettype none

module ltf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ltf_pkg::sts_t sts_i,
  output ltf_pkg::cmd_t      cmd_o
);
  import ltf_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StEval = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.idx_ok && !sts_i.restart) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.capture = 1'b1;
        state_d       = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? StMul : StOut;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoW - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ltf_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module ltf_datapath #(
  parameter int unsigned NUM_LEDS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ltf_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [ltf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire ltf_pkg::in_t                      in_data_i,
  input  wire ltf_pkg::cmd_t                     cmd_i,
  output ltf_pkg::sts_t                          sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ltf_pkg::out_t                          out_data_o
);
  import ltf_pkg::*;

  localparam int unsigned IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [8:0]  NumLeds = 9'(NUM_LEDS);

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] start;
    logic [15:0] len;
  } ent_t;

  // Configuration registers
  logic [15:0] thr_q, off_q, on_q, spread_q, restart_q;
  logic [7:0]  minb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      off_q     <= '0;
      on_q      <= '0;
      spread_q  <= '0;
      restart_q <= '0;
      minb_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreshold: thr_q     <= cfg_data_i;
        CfgOffMs:     off_q     <= cfg_data_i;
        CfgOnMs:      on_q      <= cfg_data_i;
        CfgSpreadMs:  spread_q  <= cfg_data_i;
        CfgRestartMs: restart_q <= cfg_data_i;
        CfgMinBright: minb_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Item and per-LED state
  in_t             item_q;
  ent_t            mem_q [NUM_LEDS];
  ent_t            rd_q;
  logic [1:0]      ph_q;
  logic [31:0]     d_q;
  logic [15:0]     len_q;
  logic [15:0]     sprd_q;
  logic [15:0]     rem_q;
  logic [QuoW-1:0] quo_q;
  logic [7:0]      b_q;

  logic            in_ok;
  logic            rst_we;
  logic [IdxW-1:0] in_addr;
  logic [IdxW-1:0] item_addr;
  logic [7:0]      span;
  logic [31:0]     sprd_prod;

  assign in_ok     = {3'd0, in_data_i.led_index} < NumLeds;
  assign rst_we    = cmd_i.accept && in_ok && (in_data_i.req_type == ReqRestart);
  assign in_addr   = IdxW'(in_data_i.led_index);
  assign item_addr = IdxW'(item_q.led_index);
  assign span      = FullBright - minb_q;
  assign sprd_prod = {16'd0, item_q.rand_b} * {16'd0, spread_q};

  // Phase evaluation
  logic       ev_we;
  ent_t       ev_wdata;
  logic [7:0] ev_b;
  logic       need_div;
  logic       over;

  always_comb begin
    over     = d_q > {16'd0, len_q};
    ev_we    = 1'b0;
    ev_wdata = '{phase: PhSteady, start: item_q.now_ms, len: len_q};
    ev_b     = FullBright;
    need_div = 1'b0;
    if (ph_q == PhSteady) begin
      // a fresh blink starts at d = 0, which is still full brightness
      if (item_q.rand_a < thr_q) begin
        ev_we          = 1'b1;
        ev_wdata.phase = PhDim;
        ev_wdata.len   = off_q + sprd_q;
      end
    end else if (over) begin
      ev_we = 1'b1;
      if (ph_q == PhDim) begin
        ev_wdata.phase = PhBright;
        ev_wdata.len   = on_q + sprd_q;
        ev_b           = minb_q;
      end
    end else if (len_q == '0) begin
      ev_b = (ph_q == PhDim) ? FullBright : minb_q;
    end else begin
      need_div = 1'b1;
    end
  end

  // Divider step: remainder stays below len_q
  logic [16:0] trial;
  logic        ge;
  logic [23:0] num;

  assign num   = {16'd0, span} * {8'd0, d_q[15:0]};
  assign trial = {rem_q, quo_q[QuoW-1]};
  assign ge    = trial >= {1'b0, len_q};

  logic [7:0] fin_b;
  always_comb begin
    if (ph_q == PhDim) begin
      fin_b = FullBright - (quo_q + 8'(rem_q != '0));
    end else begin
      fin_b = minb_q + quo_q;
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (rst_we) begin
      mem_q[in_addr] <= '{phase: PhBright, start: in_data_i.now_ms, len: restart_q};
    end else if (cmd_i.eval && ev_we) begin
      mem_q[item_addr] <= ev_wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.capture) begin
      ph_q   <= (rd_q.phase == PhDim || rd_q.phase == PhBright) ? rd_q.phase : PhSteady;
      d_q    <= item_q.now_ms - rd_q.start;
      len_q  <= rd_q.len;
      sprd_q <= sprd_prod[31:16];
    end
    if (cmd_i.eval) begin
      b_q <= ev_b;
    end
    if (cmd_i.mul) begin
      rem_q <= num[23:8];
      quo_q <= num[7:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 16'(trial - {1'b0, len_q}) : trial[15:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
    if (cmd_i.fin) begin
      b_q <= fin_b;
    end
  end

  // Output register
  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_index  <= item_q.led_index;
      out_q.out_red    <= scale_ch(item_q.base_red, b_q);
      out_q.out_green  <= scale_ch(item_q.base_green, b_q);
      out_q.out_blue   <= scale_ch(item_q.base_blue, b_q);
      out_q.brightness <= b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.idx_ok   = in_ok;
  assign sts_o.restart  = (in_data_i.req_type == ReqRestart);
  assign sts_o.need_div = need_div;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  `LTF_ASSERT_ALWAYS(a_load_free, cmd_i.load_out |-> (!out_valid_q || out_ready_i), "result loaded over a waiting beat")
  `LTF_ASSERT(a_div_len, cmd_i.div_step |-> (len_q != '0), "division by zero ramp length")
  `LTF_ASSERT(a_quo_span, cmd_i.fin |-> (({1'b0, quo_q} + 9'(rem_q != '0)) <= {1'b0, span}), "ramp step exceeds span")

endmodule

`default_nettype wire

// ===== bench/ltf_checker.sv =====
module ltf_checker #(
  parameter int unsigned NUM_LEDS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ltf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ltf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  ltf_pkg::in_t                 in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  ltf_pkg::out_t                out_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ltf_pkg::*;

  localparam int unsigned MaxReports = 10;

  logic [15:0] blink_thr, off_len, on_len, spread_len, restart_len;
  logic [7:0]  floor_bright;

  logic [1:0]  led_mode   [NUM_LEDS];
  logic [31:0] mode_since [NUM_LEDS];
  logic [15:0] mode_len   [NUM_LEDS];

  out_t        faded_colors [$];
  int unsigned mismatches = 0;
  int unsigned backlog = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  function automatic logic [15:0] jitter(input logic [15:0] rb);
    logic [31:0] prod;
    prod = rb * spread_len;
    return prod[31:16];
  endfunction

  function automatic logic [7:0] fade(input logic [7:0] ch, input logic [7:0] level);
    logic [15:0] acc;
    acc = ch * level + ch;
    return acc[15:8];
  endfunction

  // Advance one LED and return 1 with the faded colour when the beat gives a result.
  function automatic bit advance_led(input in_t beat, output out_t color);
    logic [5:0]  idx;
    logic [1:0]  mode;
    logic [31:0] elapsed, scaled, step;
    logic [15:0] len;
    logic [7:0]  span, level;
    color = '0;
    idx   = beat.led_index;
    if (beat.led_index >= NUM_LEDS) return 1'b0;
    if (beat.req_type == ReqRestart) begin
      led_mode[idx]   = PhBright;
      mode_since[idx] = beat.now_ms;
      mode_len[idx]   = restart_len;
      return 1'b0;
    end
    span  = FullBright - floor_bright;
    level = FullBright;
    mode  = led_mode[idx];
    // the spare phase code acts as steady
    if (mode != PhDim && mode != PhBright) mode = PhSteady;
    if (mode == PhSteady && beat.rand_a < blink_thr) begin
      mode            = PhDim;
      led_mode[idx]   = PhDim;
      mode_since[idx] = beat.now_ms;
      mode_len[idx]   = off_len + jitter(beat.rand_b);
    end
    elapsed = beat.now_ms - mode_since[idx];
    len     = mode_len[idx];
    scaled  = span * elapsed;
    if (mode == PhDim) begin
      if (elapsed > len) begin
        led_mode[idx]   = PhBright;
        mode_since[idx] = beat.now_ms;
        mode_len[idx]   = on_len + jitter(beat.rand_b);
        level           = floor_bright;
      end else if (len == '0) begin
        level = FullBright;
      end else begin
        step  = (scaled + len - 1) / len;
        level = FullBright - step[7:0];
      end
    end else if (mode == PhBright) begin
      if (elapsed > len) begin
        led_mode[idx]   = PhSteady;
        mode_since[idx] = beat.now_ms;
        level           = FullBright;
      end else if (len == '0) begin
        level = floor_bright;
      end else begin
        step  = scaled / len;
        level = floor_bright + step[7:0];
      end
    end
    color.out_index  = idx;
    color.out_red    = fade(beat.base_red, level);
    color.out_green  = fade(beat.base_green, level);
    color.out_blue   = fade(beat.base_blue, level);
    color.brightness = level;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      blink_thr    = '0;
      off_len      = '0;
      on_len       = '0;
      spread_len   = '0;
      restart_len  = '0;
      floor_bright = '0;
      faded_colors.delete();
      backlog = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgThreshold: blink_thr    = cfg_data_i;
          CfgOffMs:     off_len      = cfg_data_i;
          CfgOnMs:      on_len       = cfg_data_i;
          CfgSpreadMs:  spread_len   = cfg_data_i;
          CfgRestartMs: restart_len  = cfg_data_i;
          CfgMinBright: floor_bright = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (advance_led(in_data_i, want)) faded_colors.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (faded_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result beat with nothing expected: led %0d rgb %0d/%0d/%0d b %0d",
                     $time, out_data_i.out_index, out_data_i.out_red, out_data_i.out_green,
                     out_data_i.out_blue, out_data_i.brightness);
        end else begin
          want = faded_colors.pop_front();
          if (out_data_i.out_index  !== want.out_index  ||
              out_data_i.out_red    !== want.out_red    ||
              out_data_i.out_green  !== want.out_green  ||
              out_data_i.out_blue   !== want.out_blue   ||
              out_data_i.brightness !== want.brightness) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"%0t: mismatch: expected led %0d rgb %0d/%0d/%0d b %0d,",
                        " got led %0d rgb %0d/%0d/%0d b %0d"},
                       $time, want.out_index, want.out_red, want.out_green, want.out_blue,
                       want.brightness, out_data_i.out_index, out_data_i.out_red,
                       out_data_i.out_green, out_data_i.out_blue, out_data_i.brightness);
          end
        end
      end
      backlog = faded_colors.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ltf_pkg::*;

  localparam int unsigned NumLeds      = 64;
  localparam int unsigned RandomItems  = 400;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 20;   // longer than an update's full pass through the block
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned IdleLimit    = 2000;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] off_ms;
    logic [15:0] on_ms;
    logic [15:0] spread_ms;
    logic [15:0] restart_ms;
    logic [7:0]  min_bright;
  } fader_cfg_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  int unsigned         fail_count;
  int unsigned         pending;

  // calm turns off all idling on both sides for a whole phase
  bit          calm = 1'b0;
  // the stimulus asks for a long receiver hold-off; the receiver counts them served
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  // an LED may only be updated once a restart has defined its state
  bit          led_live [NumLeds];
  logic [31:0] clock_ms;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  led_twinkle_fader_top #(
    .NUM_LEDS(NumLeds)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ltf_checker #(
    .NUM_LEDS(NumLeds)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Ramp lengths: mostly short enough for ramps to finish, sometimes the extremes.
  function automatic logic [15:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'h0000;
    if (roll < 18) return 16'hFFFF;
    return 16'($urandom_range(400, 1));
  endfunction

  function automatic fader_cfg_t make_cfg(input logic [15:0] threshold, off_ms, on_ms,
                                          spread_ms, restart_ms, input logic [7:0] min_bright);
    fader_cfg_t c;
    c.threshold  = threshold;
    c.off_ms     = off_ms;
    c.on_ms      = on_ms;
    c.spread_ms  = spread_ms;
    c.restart_ms = restart_ms;
    c.min_bright = min_bright;
    return c;
  endfunction

  // The first two random phases pin every register to an extreme.
  function automatic fader_cfg_t pick_cfg(input int unsigned phase);
    int unsigned roll;
    logic [7:0]  floor_level;
    if (phase == 0) return make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
    if (phase == 1) return make_cfg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd255);
    roll = $urandom_range(99);
    floor_level = (roll < 15) ? 8'd0 : (roll < 30) ? 8'd255 : 8'($urandom_range(255));
    return make_cfg(16'($urandom_range(65535)), pick_len(), pick_len(), pick_len(), pick_len(),
                    floor_level);
  endfunction

  // Write one register (load_config writes them all back to back); call only while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_config(input fader_cfg_t c);
    write_reg(CfgThreshold, c.threshold);
    write_reg(CfgOffMs, c.off_ms);
    write_reg(CfgOnMs, c.on_ms);
    write_reg(CfgSpreadMs, c.spread_ms);
    write_reg(CfgRestartMs, c.restart_ms);
    write_reg(CfgMinBright, {8'd0, c.min_bright});
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every result, then let a restart still in flight finish.
  task automatic quiesce();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Offer one beat after a random gap and hold it until accepted.
  // Entered and left on a falling edge; valid stays high when the next beat follows at once.
  task automatic offer(input logic kind, input logic [5:0] idx, input logic [31:0] now,
                       input logic [15:0] ra, input logic [15:0] rb,
                       input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
    int unsigned gap;
    in_t         beat;
    beat.req_type   = kind;
    beat.led_index  = idx;
    beat.now_ms     = now;
    beat.rand_a     = ra;
    beat.rand_b     = rb;
    beat.base_red   = red;
    beat.base_green = green;
    beat.base_blue  = blue;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (kind == ReqRestart) led_live[idx] = 1'b1;
    @(negedge clk);
  endtask

  // One random beat, mostly on the phase's pool of LEDs, with time moving at a pace
  // tuned to the ramp lengths so that ramps are caught at every point.
  task automatic random_item(input fader_cfg_t c, input int unsigned pool_base,
                             input int unsigned pool_size);
    int unsigned roll, pick, reach;
    logic [5:0]  idx;
    logic [15:0] ra;
    logic        kind;
    pick  = (pool_base + $urandom_range(pool_size - 1)) % NumLeds;
    idx   = pick[5:0];
    reach = ((c.off_ms > c.on_ms) ? c.off_ms : c.on_ms) + c.spread_ms + c.restart_ms / 2 + 4;
    roll  = $urandom_range(99);
    if (roll < 6) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range((2 * reach) / pool_size + 1);
    roll = $urandom_range(99);
    if (roll < 10) begin
      // restart some LED anywhere, touching every index over the run
      pick = $urandom_range(NumLeds - 1);
      idx  = pick[5:0];
      kind = ReqRestart;
    end else begin
      kind = led_live[idx] ? ReqUpdate : ReqRestart;
    end
    roll = $urandom_range(99);
    ra = (roll < 10) ? 16'h0000 : (roll < 20) ? 16'hFFFF : 16'($urandom_range(65535));
    offer(kind, idx, clock_ms, ra, 16'($urandom_range(65535)), 8'($urandom_range(255)),
          8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Receiver: ready most of the time, random stalls, and the long hold-offs
  // the stimulus asks for, counted here in cycles.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk);
        holds_done++;
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = ($urandom_range(99) < 30) ? pick_gap() : 0;
        if (stall_left == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // Watchdog: end the run if no beat and no register write moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("led_twinkle_fader_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    fader_cfg_t  setting;
    int unsigned phase, n, pool_base, pool_size, per_phase;
    foreach (led_live[i]) led_live[i] = 1'b0;
    clock_ms  = $urandom();
    per_phase = RandomItems / NumPhases + 1;

    // Hold reset, release on a falling edge.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SettleCycles) @(negedge clk);

    // Directed: walk LED 0 through every phase with exact timing, spread off.
    load_config(make_cfg(16'hFFFF, 16'd100, 16'd200, 16'd0, 16'd0, 8'd0));
    offer(ReqRestart, 6'd0, 32'd1000, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    // zero-length brightening ramp: start value
    offer(ReqUpdate, 6'd0, 32'd1000, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd1001, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'h80);
    // steady and random word not below the threshold: no blink
    offer(ReqUpdate, 6'd0, 32'd1001, 16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h01);
    offer(ReqUpdate, 6'd0, 32'd2000, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd2050, 16'h1234, 16'h0000, 8'hFF, 8'h7F, 8'h01);
    // end of the dimming ramp exactly, then one past it
    offer(ReqUpdate, 6'd0, 32'd2100, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd2101, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd2201, 16'hFFFF, 16'h0000, 8'hAA, 8'h55, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd2401, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd0, 32'd2402, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    // top index at the top of time
    offer(ReqRestart, 6'd63, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    offer(ReqUpdate, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    quiesce();

    // Directed: time wrap, ramp length wrap to zero and to near full.
    load_config(make_cfg(16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd200));
    offer(ReqRestart, 6'd2, 32'hFFFF_FF00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
    offer(ReqUpdate, 6'd2, 32'h0000_0100, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd2, 32'h0001_0100, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    // off plus spread wraps to zero: zero-length dimming ramp
    offer(ReqUpdate, 6'd2, 32'h0001_0100, 16'h0000, 16'hFFFF, 8'hFF, 8'h80, 8'h40);
    offer(ReqUpdate, 6'd2, 32'h0001_0101, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqUpdate, 6'd2, 32'h0001_8101, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    offer(ReqRestart, 6'd63, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
    offer(ReqUpdate, 6'd63, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    quiesce();

    // Random phases: new settings each time, a different pool of LEDs,
    // and the sender paused until every result has come before each change.
    for (phase = 0; phase < NumPhases; phase++) begin
      setting = pick_cfg(phase);
      load_config(setting);
      calm      = (phase == 1 || phase == 4);
      pool_size = (phase % 3 == 0) ? 64 : (phase % 3 == 1) ? 3 : 12;
      pool_base = $urandom_range(NumLeds - 1);
      for (n = 0; n < per_phase; n++) begin
        // fill the block against a stalled receiver while beats keep coming
        if (phase == 2 && n == 10) holds_asked++;
        random_item(setting, pool_base, pool_size);
      end
      quiesce();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("led_twinkle_fader_top regression: pass");
    end else begin
      $display("led_twinkle_fader_top regression: fail");
    end
    $finish;
  end

endmodule
